// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/i2rs_pkg.sv -----
// ----------------------------------------------------------------------------
// i2rs_pkg
// Types, constants and helpers shared by the radix string converter.
// ----------------------------------------------------------------------------
package i2rs_pkg;

    localparam int DEFAULT_VALUE_BITS = 64;
    localparam int DEFAULT_MAX_DIGITS = 64;

    localparam int VALUE_W = 64;
    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;

    localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7a;
    localparam logic [CHAR_W-1:0] ALPHA_OFFSET = ASCII_LOWER_A - 8'd10;

    // Control broadcast to every digit cell.
    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    // Carry that travels from one cell to its more significant neighbor.
    typedef struct packed {
        logic valid;
        logic carry;
    } cell_link_t;

    // Maps a digit value to its ASCII character.
    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        dw = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d > DIGIT_NINE)
            return dw + ALPHA_OFFSET;
        return dw + ASCII_ZERO;
    endfunction

endpackage

// ----- design/i2rs_cell.sv -----
// ----------------------------------------------------------------------------
// i2rs_cell
// One digit cell: clears, shifts in, or doubles, adds a bit, reduces by radix.
// ----------------------------------------------------------------------------
module i2rs_cell
    import i2rs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [RADIX_W-1:0] radix,
    input  cell_ctrl_t         ctrl,
    input  cell_link_t         link_in,
    input  logic [DIGIT_W-1:0] shift_in,
    output cell_link_t         link_out,
    output logic [DIGIT_W-1:0] digit
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    cell_link_t         link_reg;
    cell_link_t         link_next;

    logic [DIGIT_W:0] doubled;
    logic [DIGIT_W:0] reduced;
    logic             wrap;

    // The digit is always below the radix, so one subtraction is enough.
    assign doubled = {digit_reg, link_in.carry};
    assign reduced = doubled - {1'b0, radix};
    assign wrap    = (doubled >= {1'b0, radix});

    always_comb
    begin
        digit_next      = digit_reg;
        link_next.valid = 1'b0;
        link_next.carry = 1'b0;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.shift)
        begin
            digit_next = shift_in;
        end
        else if (link_in.valid)
        begin
            digit_next      = wrap ? reduced[DIGIT_W-1:0] : doubled[DIGIT_W-1:0];
            link_next.valid = 1'b1;
            link_next.carry = wrap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
            link_reg  <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
            link_reg  <= link_next;
        end
    end

    assign digit    = digit_reg;
    assign link_out = link_reg;

endmodule

// ----- design/integer_to_radix_string.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_string
// Converts an unsigned binary value to ASCII digits in a radix from 2 to 36.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high while busy is low. The block
// then stays busy for a time that does not depend on the value or radix.
// It first feeds the value's bits, most significant first, into a row of
// MAX_DIGITS digit cells; each carry moves one cell per cycle, so the
// conversion goes on until the carries of the last bit have reached the
// last cell. It then shifts the whole row out from its most significant
// end, one digit per cycle, skipping leading zeros as it goes, and goes idle
// when the least significant digit has been shifted out. Characters
// appear on character and last_char for one cycle each, marked by strobe,
// most significant first, one per cycle with no gaps once the first has
// appeared; last_char marks the final one. The receiver cannot stall the
// output, so it must take every strobe. A zero value yields the single
// character '0'. A radix below two counts as two, one above thirty-six as
// thirty-six. Only the low VALUE_BITS bits of value are used, and if the
// number needs more than MAX_DIGITS digits only the least significant
// MAX_DIGITS digits are produced, zeros at their top included. busy falls in
// the cycle that shows the last character, so a new start may be taken in
// that very cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_to_radix_string
    import i2rs_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS,
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] value,
    input  logic [RADIX_W-1:0] radix,
    output logic               busy,
    output logic               strobe,
    output logic [CHAR_W-1:0]  character,
    output logic               last_char
);

    localparam int CONV_CYCLES = VALUE_BITS + MAX_DIGITS - 1;
    localparam int CNT_W       = $clog2(CONV_CYCLES);
    localparam int REM_W       = $clog2(MAX_DIGITS + 1);

    typedef enum logic [1:0] {
        IDLE,
        CONV,
        EMIT
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [REM_W-1:0]       remain_reg;
    logic                   started_reg;
    logic                   overflow_reg;
    logic [VALUE_BITS-1:0]  shift_reg;
    logic [RADIX_W-1:0]     radix_reg;
    logic                   strobe_reg;
    logic [CHAR_W-1:0]      character_reg;
    logic                   last_char_reg;

    logic [RADIX_W-1:0]     radix_clamped;
    logic                   accept;
    logic [DIGIT_W-1:0]     top_digit;
    logic                   overflow;
    logic                   skip_zero;

    cell_ctrl_t             ctrl;
    cell_link_t             link_w [MAX_DIGITS+1];
    logic [DIGIT_W-1:0]     digit_w [MAX_DIGITS];

    assign accept = start && (state_reg == IDLE);

    always_comb
    begin
        if (radix < RADIX_MIN)
            radix_clamped = RADIX_MIN;
        else if (radix > RADIX_MAX)
            radix_clamped = RADIX_MAX;
        else
            radix_clamped = radix;
    end

    // Clear the row when a transaction is taken; shift it out while emitting.
    assign ctrl.clear = accept;
    assign ctrl.shift = (state_reg == EMIT);

    // Bits enter cell 0 most significant first, one per conversion cycle, until the last bit is in.
    assign link_w[0].valid = (state_reg == CONV) && (cnt_reg < CNT_W'(VALUE_BITS));
    assign link_w[0].carry = shift_reg[VALUE_BITS-1];

    // Cell 0 holds the least significant digit; the carry out of the last
    // cell is the part of the number beyond MAX_DIGITS digits and is dropped.
    for (genvar i = 0; i < MAX_DIGITS; i++)
    begin : g_cell
        logic [DIGIT_W-1:0] shift_in;
        if (i == 0)
        begin : g_first
            assign shift_in = '0;
        end
        else
        begin : g_rest
            assign shift_in = digit_w[i-1];
        end

        i2rs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .radix    (radix_reg),
            .ctrl     (ctrl),
            .link_in  (link_w[i]),
            .shift_in (shift_in),
            .link_out (link_w[i+1]),
            .digit    (digit_w[i])
        );
    end

    assign top_digit = digit_w[MAX_DIGITS-1];

    // A set carry out of the last cell means the number has more digits than
    // the row holds. The final such carry lands in the first emit cycle, so
    // it is looked at directly as well as through the sticky flag.
    assign overflow = overflow_reg ||
                      (link_w[MAX_DIGITS].valid && link_w[MAX_DIGITS].carry);

    // A leading zero is passed over unless it is the only digit left, or the
    // digits shown are only the low part of a longer number.
    assign skip_zero = !started_reg && !overflow && (top_digit == '0) &&
                       (remain_reg != REM_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            cnt_reg       <= '0;
            remain_reg    <= '0;
            started_reg   <= 1'b0;
            overflow_reg  <= 1'b0;
            shift_reg     <= '0;
            radix_reg     <= RADIX_MIN;
            strobe_reg    <= 1'b0;
            character_reg <= '0;
            last_char_reg <= 1'b0;
        end
        else
        begin
            strobe_reg    <= 1'b0;
            last_char_reg <= 1'b0;
            case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        shift_reg    <= value[VALUE_BITS-1:0];
                        radix_reg    <= radix_clamped;
                        cnt_reg      <= '0;
                        overflow_reg <= 1'b0;
                        state_reg    <= CONV;
                    end
                end
                CONV:
                begin
                    shift_reg <= shift_reg << 1;
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (overflow)
                        overflow_reg <= 1'b1;
                    if (cnt_reg == CNT_W'(CONV_CYCLES - 1))
                    begin
                        remain_reg  <= REM_W'(MAX_DIGITS);
                        started_reg <= 1'b0;
                        state_reg   <= EMIT;
                    end
                end
                EMIT:
                begin
                    remain_reg <= remain_reg - 1'b1;
                    if (!skip_zero)
                    begin
                        started_reg   <= 1'b1;
                        strobe_reg    <= 1'b1;
                        character_reg <= ascii_of(top_digit);
                        last_char_reg <= (remain_reg == REM_W'(1));
                    end
                    if (remain_reg == REM_W'(1))
                        state_reg <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != IDLE);
    assign strobe    = strobe_reg;
    assign character = character_reg;
    assign last_char = last_char_reg;

    // Once the first character is out, the rest follow without a gap.
    `ASSERT_NEXT(a_no_gap, clk, rst_n, strobe && !last_char, strobe)
    // The final character coincides with the block going idle.
    `ASSERT_SAME(a_last_idle, clk, rst_n, strobe && last_char, !busy)
    // Only the carry out of the last cell may still be in flight while the
    // digits shift out; no carry reaches the last cell any more.
    `ASSERT_SAME(a_row_settled, clk, rst_n, state_reg == EMIT, !link_w[MAX_DIGITS-1].valid)
    // Every character is a decimal digit or a lower-case letter.
    `ASSERT_SAME(a_char_range, clk, rst_n, strobe,
        (character >= ASCII_ZERO && character <= ASCII_NINE) ||
        (character >= ASCII_LOWER_A && character <= ASCII_LOWER_Z))

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Radix string converter testbench
// Sends values with a radix to the converter, predicts or looks up the ASCII
// digit string of each one and checks every strobed character against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import i2rs_pkg::*;

    // Digits are never truncated at the default sizes: a 64-bit value needs
    // at most 64 binary digits, which is exactly the number of digit cells.
    localparam int NUM_DIGITS = DEFAULT_MAX_DIGITS;
    localparam int RANDOM_ITEMS = 290;
    localparam int DIR_N = 21;

    // Busy time of one transaction, in clock cycles; the waits below are sized from it.
    localparam int BUSY_CYCLES = DEFAULT_VALUE_BITS + 2 * DEFAULT_MAX_DIGITS - 1;
    localparam int DRAIN_LIMIT = 4 * BUSY_CYCLES;
    localparam int SETTLE_CYCLES = BUSY_CYCLES + 10;
    localparam int REPORT_LIMIT = 10;

    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;

    // One expected character of the output string.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_rec_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [VALUE_W-1:0] value = '0;
    logic [RADIX_W-1:0] radix = '0;
    logic               busy;
    logic               strobe;
    logic [CHAR_W-1:0]  character;
    logic               last_char;

    // Characters still owed by the block, oldest first.
    char_rec_t pending_chars[$];
    int        fault_count = 0;

    // Directed table. A non-empty text is the string that the row must
    // produce; an empty text means the row is checked against the predictor.
    logic [VALUE_W-1:0] dir_value [DIR_N] = '{
        64'd0,
        64'd0,
        64'd0,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'd35,
        64'd10,
        64'd9,
        64'd10,
        64'd5,
        64'd6,
        64'd35,
        64'd36,
        64'd1,
        64'h8000_0000_0000_0000,
        64'h8000_0000_0000_0000,
        64'd255,
        64'd1295,
        64'hAAAA_AAAA_AAAA_AAAA
    };
    logic [RADIX_W-1:0] dir_radix [DIR_N] = '{
        6'd10, 6'd2, 6'd36, 6'd16, 6'd2, 6'd10, 6'd36, 6'd36, 6'd36, 6'd10,
        6'd10, 6'd0, 6'd1, 6'd37, 6'd63, 6'd2, 6'd2, 6'd8, 6'd16, 6'd36, 6'd3
    };
    string dir_text [DIR_N] = '{
        "0",
        "0",
        "0",
        "ffffffffffffffff",
        "",
        "18446744073709551615",
        "",
        "z",
        "a",
        "9",
        "10",
        "101",
        "110",
        "z",
        "10",
        "1",
        "",
        "1000000000000000000000",
        "ff",
        "zz",
        ""
    };

    integer_to_radix_string dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .value     (value),
        .radix     (radix),
        .busy      (busy),
        .strobe    (strobe),
        .character (character),
        .last_char (last_char)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Counts a failure and reports only the first few of them.
    task automatic flag_error(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Maps one digit value to its lower-case ASCII character.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        if (d < DIGIT_TEN)
            return ASCII_ZERO + {2'b00, d};
        return ASCII_LOWER_A + {2'b00, d - DIGIT_TEN};
    endfunction

    // Works out the digit string of one transaction and queues it, most
    // significant character first. Out-of-range radixes are clamped the same
    // way the block clamps them.
    task automatic predict_digits(input logic [VALUE_W-1:0] v,
                                  input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] base;
        logic [VALUE_W-1:0] rest;
        logic [VALUE_W-1:0] wide_base;
        logic [DIGIT_W-1:0] digs [NUM_DIGITS];
        int                 n;
        char_rec_t          rec;
        base = r;
        if (base < RADIX_MIN)
            base = RADIX_MIN;
        if (base > RADIX_MAX)
            base = RADIX_MAX;
        wide_base = {{(VALUE_W-RADIX_W){1'b0}}, base};
        rest = v;
        n = 0;
        // A zero value still yields one digit, hence the loop runs once first.
        do
        begin
            digs[n] = DIGIT_W'(rest % wide_base);
            rest = rest / wide_base;
            n++;
        end while (rest != 0 && n < NUM_DIGITS);
        for (int k = n - 1; k >= 0; k--)
        begin
            rec.ch = digit_char(digs[k]);
            rec.last = (k == 0);
            pending_chars.push_back(rec);
        end
    endtask

    // Queues a string typed into the directed table.
    task automatic queue_text(input string s);
        char_rec_t rec;
        for (int i = 0; i < s.len(); i++)
        begin
            rec.ch = s[i];
            rec.last = (i == s.len() - 1);
            pending_chars.push_back(rec);
        end
    endtask

    // Random values mix full-width patterns, values of random bit length, small
    // numbers, zero and the power-of-two boundaries where binary digit counts change.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        int                 w;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            5, 6:
            begin
                w = $urandom_range(1, VALUE_W);
                if (w < VALUE_W)
                    v = v & ((64'd1 << w) - 64'd1);
            end
            7: v = 64'($urandom_range(0, 1000));
            8:
            begin
                w = $urandom_range(0, VALUE_W - 1);
                case ($urandom_range(0, 2))
                    0: v = 64'd1 << w;
                    1: v = (64'd1 << w) - 64'd1;
                    default: v = '1;
                endcase
            end
            9: v = '0;
            default: ;
        endcase
        return v;
    endfunction

    // Mostly legal radixes, with the common bases favored and a share of raw
    // six-bit values so that the clamping is exercised too.
    function automatic logic [RADIX_W-1:0] pick_radix();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 8)
            return RADIX_W'($urandom_range(2, 36));
        if (sel == 8)
        begin
            case ($urandom_range(0, 3))
                0: return RADIX_W'(2);
                1: return RADIX_W'(10);
                2: return RADIX_W'(16);
                default: return RADIX_W'(36);
            endcase
        end
        return RADIX_W'($urandom_range(0, 63));
    endfunction

    // Idle cycles before the next start. The spread of gap lengths makes start
    // rise during every phase of the conversion and of the character output.
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 7)
            return 0;
        if (sel < 14)
            return $urandom_range(1, 20);
        if (sel < 18)
            return $urandom_range(21, 200);
        return $urandom_range(201, 400);
    endfunction

    // Presents one transaction and holds it until the block takes it. The
    // transaction is accepted at the first edge where start is high and busy
    // is low; the expectation is queued right at that edge.
    task automatic send_item(input logic [VALUE_W-1:0] v,
                             input logic [RADIX_W-1:0] r,
                             input int gap,
                             input string text);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        radix <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (text.len() > 0)
            queue_text(text);
        else
            predict_digits(v, r);
    endtask

    // Result monitor. Values are read right after the edge, before any
    // update of that edge lands, so they are the ones the edge captured.
    always @(posedge clk)
    begin
        char_rec_t want;
        if (rst_n && strobe === 1'b1)
        begin
            if (pending_chars.size() == 0)
                flag_error($sformatf("unexpected character %h last %b",
                                     character, last_char));
            else
            begin
                want = pending_chars.pop_front();
                if (character !== want.ch || last_char !== want.last)
                    flag_error($sformatf("expected char %h last %b, got char %h last %b",
                                         want.ch, want.last, character, last_char));
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int burst;
        int gap;
        int waited;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows first, sent back to back.
        for (int i = 0; i < DIR_N; i++)
            send_item(dir_value[i], dir_radix[i], 0, dir_text[i]);

        // Random transactions. Now and then a burst of back-to-back starts
        // keeps the block saturated: each new start is taken as soon as busy falls.
        burst = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (burst == 0 && $urandom_range(0, 24) == 0)
                burst = $urandom_range(5, 15);
            if (burst > 0)
            begin
                gap = 0;
                burst--;
            end
            else
                gap = pick_gap();
            send_item(pick_value(), pick_radix(), gap, "");
        end
        start <= 1'b0;

        // Wait for every owed character, then a little longer so that any
        // stray character would still be caught.
        waited = 0;
        while (pending_chars.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_chars.size() != 0)
            flag_error($sformatf("%0d characters never arrived", pending_chars.size()));

        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: the slowest legal run ends far sooner than this.
    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/i2rs_pkg.sv
design/i2rs_cell.sv
design/integer_to_radix_string.sv
tb/sv/testbench.sv
